FILE: design/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the pulse-width throttle sweep generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  localparam int LEVEL_BITS = 8;
  localparam int WIDTH_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int INDEX_BITS = 2;

  // level times gain fits in this many bits
  localparam int SPAN_BITS = LEVEL_BITS + 4;

  localparam int SPAN_UNI_GAIN = 10;
  localparam int SPAN_BI_GAIN  = 5;

  localparam logic [WIDTH_BITS-1:0] PULSE_MIN_RST = WIDTH_BITS'(1000);
  localparam logic [WIDTH_BITS-1:0] PULSE_MID_RST = WIDTH_BITS'(1500);

  typedef enum logic [2:0] {
    MODE_OFF         = 3'd0,
    MODE_SWEEP_UNI   = 3'd1,
    MODE_FIXED_UNI   = 3'd2,
    MODE_SWEEP_BI    = 3'd3,
    MODE_SWEEP_SIDE  = 3'd4,
    MODE_FIXED_BI    = 3'd5
  } mode_t;

  typedef enum logic [INDEX_BITS-1:0] {
    REG_DRIVE_MODE = 2'd0,
    REG_PULSE_MIN  = 2'd1,
    REG_PULSE_MID  = 2'd2
  } reg_index_t;

endpackage

`default_nettype wire

FILE: design/pwm_throttle_sweep_generator.sv
// ----------------------------------------------------------------------------
// pwm_throttle_sweep_generator
// Moves a servo pulse-width value by at most one count per input beat, as the
// drive mode selects (the off mode clears it to 0), and returns the new width
// with a direction indicator.
// Input channel: item_valid / item_stall carry adc_level, one beat per tick while item_stall is low.
// Output channel: result_valid / result_stall carry pulse_width and led_on.
// Configuration: cfg_we with cfg_index and cfg_data writes drive_mode, pulse_min or
// pulse_mid; the user must write only while no beat is in flight; not enforced.
// Pipeline: an accepted input beat passes the input register, then the result
// register that also updates the width state.
// Throughput: one beat per cycle while result_stall does not hold the output; the width
// and direction state is read and written in the same cycle, so consecutive beats never wait on it.
// Reset: both stages empty, width 0, direction rising, mode off,
// pulse_min 1000, pulse_mid 1500.
// Stall: a stalled result holds; the input register still takes a beat if it
// is empty, and item_stall rises only when both stages are full and blocked.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_throttle_sweep_generator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_stall,
  input  wire logic [pts_pkg::LEVEL_BITS-1:0]   adc_level,
  output logic                                  result_valid,
  input  wire logic                             result_stall,
  output logic [pts_pkg::WIDTH_BITS-1:0]        pulse_width,
  output logic                                  led_on,
  input  wire logic                             cfg_we,
  input  wire logic [pts_pkg::INDEX_BITS-1:0]   cfg_index,
  input  wire logic [pts_pkg::CFG_BITS-1:0]     cfg_data
);

  localparam int WB = pts_pkg::WIDTH_BITS;
  localparam int SB = pts_pkg::SPAN_BITS;

  pts_pkg::mode_t    drive_mode;
  logic [WB-1:0]     pulse_min;
  logic [WB-1:0]     pulse_mid;

  logic [WB-1:0]     width_reg;
  logic [WB-1:0]     width_next;
  logic              rising;
  logic              rising_next;

  logic                           level_valid;
  logic [pts_pkg::LEVEL_BITS-1:0] level;

  logic              advance;
  logic              step;

  logic [SB-1:0]     span_uni;
  logic [SB-1:0]     span_bi;
  logic [WB-1:0]     up_uni;
  logic [WB-1:0]     up_bi;
  logic [WB-1:0]     lo_bi;
  logic [WB-1:0]     width_inc;
  logic [WB-1:0]     width_dec;
  logic [WB-1:0]     bound_lo;
  logic [WB-1:0]     bound_hi;
  logic [WB-1:0]     target;
  logic              do_sweep;
  logic              do_approach;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode <= pts_pkg::MODE_OFF;
      pulse_min  <= pts_pkg::PULSE_MIN_RST;
      pulse_mid  <= pts_pkg::PULSE_MID_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pts_pkg::REG_DRIVE_MODE: drive_mode <= pts_pkg::mode_t'(cfg_data[2:0]);
        pts_pkg::REG_PULSE_MIN:  pulse_min  <= WB'(cfg_data);
        pts_pkg::REG_PULSE_MID:  pulse_mid  <= WB'(cfg_data);
        default: ;
      endcase
    end
  end

  // handshake
  assign advance    = !(result_valid && result_stall);
  assign item_stall = level_valid && !advance;
  assign step       = level_valid && advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      level_valid <= 1'b0;
    end else if (!item_stall) begin
      level_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      level <= adc_level;
    end
  end

  // bounds and step
  always_comb begin
    span_uni  = SB'(level) * SB'(pts_pkg::SPAN_UNI_GAIN);
    span_bi   = SB'(level) * SB'(pts_pkg::SPAN_BI_GAIN);
    up_uni    = pulse_min + WB'(span_uni);
    up_bi     = pulse_mid + WB'(span_bi);
    lo_bi     = pulse_mid - WB'(span_bi);
    width_inc = width_reg + WB'(1);
    width_dec = width_reg - WB'(1);
  end

  always_comb begin
    width_next  = width_reg;
    rising_next = rising;
    bound_lo    = pulse_min;
    bound_hi    = up_uni;
    target      = up_uni;
    do_sweep    = 1'b0;
    do_approach = 1'b0;

    unique case (drive_mode)
      pts_pkg::MODE_OFF: width_next = '0;
      pts_pkg::MODE_SWEEP_UNI: begin
        do_sweep = 1'b1;
        bound_lo = pulse_min;
        bound_hi = up_uni;
      end
      pts_pkg::MODE_FIXED_UNI: begin
        do_approach = 1'b1;
        target      = up_uni;
      end
      pts_pkg::MODE_SWEEP_BI: begin
        do_sweep = 1'b1;
        bound_lo = lo_bi;
        bound_hi = up_bi;
      end
      pts_pkg::MODE_SWEEP_SIDE: begin
        do_sweep = 1'b1;
        bound_lo = pulse_mid;
        bound_hi = up_bi;
      end
      pts_pkg::MODE_FIXED_BI: begin
        do_approach = 1'b1;
        target      = up_bi;
      end
      default: ;
    endcase

    if (do_sweep) begin
      if (width_reg >= bound_hi) begin
        rising_next = 1'b0;
      end else if (width_reg <= bound_lo) begin
        rising_next = 1'b1;
      end
      width_next = rising_next ? width_inc : width_dec;
    end

    if (do_approach) begin
      if (width_reg < target) begin
        width_next = width_inc;
      end else if (width_reg > target) begin
        width_next = width_dec;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg    <= '0;
      rising       <= 1'b1;
      result_valid <= 1'b0;
    end else begin
      if (step) begin
        width_reg <= width_next;
        rising    <= rising_next;
      end
      if (advance) begin
        result_valid <= level_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pulse_width <= width_next;
      led_on      <= rising;
    end
  end

endmodule

`default_nettype wire

FILE: design/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker
// Port-level checks for the pulse-width throttle sweep generator.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           item_valid,
  input wire logic                           item_stall,
  input wire logic                           result_valid,
  input wire logic                           result_stall,
  input wire logic [pts_pkg::WIDTH_BITS-1:0] pulse_width,
  input wire logic                           led_on
);

  // the result stage comes up empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat present after reset");

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(pulse_width) && $stable(led_on))
    else $error("stalled result beat changed");

  // input back-pressure only when a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("input stalled with empty output");

  // an accepted beat passes the input register and reaches the output when result_stall stays low
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && !result_stall) ##1 !result_stall |=> result_valid)
    else $error("result beat missing after two cycles");

endmodule

bind pwm_throttle_sweep_generator pts_checker u_pts_checker (.*);

`default_nettype wire
